>>> design/ccspd_pkg.sv
// Shared types, constants and decode functions for the character cell pixel decoder.
`default_nettype none

package ccspd_pkg;

  typedef enum logic [1:0] {
    PM_ONE  = 2'd0,
    PM_TWO  = 2'd1,
    PM_FOUR = 2'd2
  } pixel_mode_e;

  localparam logic [14:0] WRAP_OFFSETS [4] = '{15'h4000, 15'h6000, 15'h3000, 15'h5800};

  localparam logic [3:0] FG_ONE  = 4'd8;
  localparam logic [3:0] FG_TWO  = 4'd10;
  localparam logic [3:0] FG_FOUR = 4'd7;

  // Effective configuration, geometry already clamped
  typedef struct packed {
    logic [13:0] start_address;
    logic [13:0] cursor_address;
    logic [7:0]  cells;
    logic [7:0]  cells_m1;
    logic [6:0]  rows_m1;
    logic [5:0]  lines;
    logic [4:0]  lines_m1;
    logic [1:0]  pixel_mode;
    logic [1:0]  wrap_select;
  } cfg_t;

  // Input register contents
  typedef struct packed {
    logic [7:0] screen_byte;
    logic [4:0] scanline;
    logic [7:0] column;
    logic [6:0] row;
    logic       last_line;
    logic       frame_end;
  } stage_t;

  function automatic logic [14:0] wrap_addr(input logic [15:0] a, input logic [1:0] sel);
    logic [14:0] sum;
    sum = a[14:0] + WRAP_OFFSETS[sel];
    return a[15] ? sum : a[14:0];
  endfunction

  function automatic logic [31:0] decode_byte(input logic [7:0] b, input logic [1:0] mode);
    logic [31:0] res;
    logic [3:0]  left;
    logic [3:0]  right;
    logic [3:0]  v;
    res   = '0;
    left  = {b[7], b[5], b[3], b[1]};
    right = {b[6], b[4], b[2], b[0]};
    unique case (mode)
      PM_ONE: begin
        for (int p = 0; p < 8; p++) begin
          res[31 - 4*p -: 4] = {b[7 - p], 3'b000};
        end
      end
      PM_TWO: begin
        for (int p = 0; p < 4; p++) begin
          v = {b[7 - p], 1'b0, b[3 - p], 1'b0};
          res[31 - 8*p -: 8] = {v, v};
        end
      end
      default: begin
        res = {left, left, left, left, right, right, right, right};
      end
    endcase
    return res;
  endfunction

  function automatic logic [3:0] cursor_fg(input logic [1:0] mode);
    logic [3:0] fg;
    unique case (mode)
      PM_ONE:  fg = FG_ONE;
      PM_TWO:  fg = FG_TWO;
      default: fg = FG_FOUR;
    endcase
    return fg;
  endfunction

endpackage

`default_nettype wire

>>> design/ccspd_scan.sv
// Scan position counters and the input register.
`default_nettype none

module ccspd_scan (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ccspd_pkg::cfg_t      cfg_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           screen_byte_i,
  input  wire logic                 advance_i,
  output logic                      stage_valid_o,
  output ccspd_pkg::stage_t         stage_o
);

  logic              stage_valid_q;
  ccspd_pkg::stage_t stage_q;
  logic [4:0]        scanline_q, scanline_d;
  logic [7:0]        column_q, column_d;
  logic [6:0]        row_q, row_d;
  logic              accept;
  logic              last_line, last_col, last_row, frame_end;

  assign in_ready_o = !stage_valid_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  assign last_line = scanline_q >= cfg_i.lines_m1;
  assign last_col  = column_q >= cfg_i.cells_m1;
  assign last_row  = row_q >= cfg_i.rows_m1;
  assign frame_end = last_line && last_col && last_row;

  always_comb begin
    scanline_d = scanline_q;
    column_d   = column_q;
    row_d      = row_q;
    if (!last_line) begin
      scanline_d = scanline_q + 5'd1;
    end else begin
      scanline_d = '0;
      if (!last_col) begin
        column_d = column_q + 8'd1;
      end else begin
        column_d = '0;
        row_d    = last_row ? 7'd0 : row_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scanline_q    <= '0;
      column_q      <= '0;
      row_q         <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        scanline_q    <= scanline_d;
        column_q      <= column_d;
        row_q         <= row_d;
        stage_valid_q <= 1'b1;
      end else if (advance_i) begin
        stage_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q.screen_byte <= screen_byte_i;
      stage_q.scanline    <= scanline_q;
      stage_q.column      <= column_q;
      stage_q.row         <= row_q;
      stage_q.last_line   <= last_line;
      stage_q.frame_end   <= frame_end;
    end
  end

  assign stage_valid_o = stage_valid_q;
  assign stage_o       = stage_q;

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && frame_end |=> scanline_q == 5'd0 && column_q == 8'd0 && row_q == 7'd0)
    else $error("counters not cleared after frame end");

  a_line_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !last_line |=> scanline_q == $past(scanline_q) + 5'd1
                             && column_q == $past(column_q) && row_q == $past(row_q))
    else $error("scanline step wrong");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid_q && !advance_i && !accept |=> $stable(stage_q))
    else $error("held word changed");

endmodule

`default_nettype wire

>>> design/ccspd_out.sv
// Address wrap, pixel decode, cursor bar and the result register.
`default_nettype none

module ccspd_out (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ccspd_pkg::cfg_t      cfg_i,
  input  wire logic                 stage_valid_i,
  input  wire ccspd_pkg::stage_t    stage_i,
  output logic                      advance_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [14:0]               byte_address_o,
  output logic [10:0]               pixel_x_o,
  output logic [11:0]               pixel_y_o,
  output logic [31:0]               pixel_colours_o,
  output logic                      cursor_drawn_o,
  output logic                      frame_end_o
);

  logic        out_valid_q;
  logic [14:0] byte_address_q;
  logic [10:0] pixel_x_q;
  logic [11:0] pixel_y_q;
  logic [31:0] pixel_colours_q;
  logic        cursor_drawn_q;
  logic        frame_end_q;

  logic [12:0] row_cells;
  logic [11:0] row_lines;
  logic [15:0] cell_sum;
  logic [14:0] cell_addr;
  logic [15:0] byte_sum;
  logic [14:0] byte_addr;
  logic [14:0] cursor_addr;
  logic        cursor_bar;
  logic [31:0] colours;
  logic [11:0] pixel_y;

  assign advance_o = stage_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    row_cells   = 13'(stage_i.row) * 13'(cfg_i.cells);
    row_lines   = 12'(stage_i.row) * 12'(cfg_i.lines);
    cell_sum    = {cfg_i.start_address[12:0], 3'b000} + {row_cells, 3'b000}
                  + {5'b00000, stage_i.column, 3'b000};
    cell_addr   = ccspd_pkg::wrap_addr(cell_sum, cfg_i.wrap_select);
    byte_sum    = {1'b0, cell_addr} + {11'd0, stage_i.scanline};
    byte_addr   = ccspd_pkg::wrap_addr(byte_sum, cfg_i.wrap_select);
    cursor_addr = ccspd_pkg::wrap_addr({cfg_i.cursor_address[12:0], 3'b000},
                                       cfg_i.wrap_select);
    cursor_bar  = stage_i.last_line && (cell_addr == cursor_addr);
    colours     = cursor_bar ? {8{ccspd_pkg::cursor_fg(cfg_i.pixel_mode)}}
                             : ccspd_pkg::decode_byte(stage_i.screen_byte, cfg_i.pixel_mode);
    pixel_y     = row_lines + {7'd0, stage_i.scanline};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (advance_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      byte_address_q  <= byte_addr;
      pixel_x_q       <= {stage_i.column, 3'b000};
      pixel_y_q       <= pixel_y;
      pixel_colours_q <= colours;
      cursor_drawn_q  <= cursor_bar;
      frame_end_q     <= stage_i.frame_end;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign byte_address_o  = byte_address_q;
  assign pixel_x_o       = pixel_x_q;
  assign pixel_y_o       = pixel_y_q;
  assign pixel_colours_o = pixel_colours_q;
  assign cursor_drawn_o  = cursor_drawn_q;
  assign frame_end_o     = frame_end_q;

  a_bar_solid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && cursor_drawn_q |-> pixel_colours_q == {8{pixel_colours_q[3:0]}})
    else $error("cursor bar not a solid colour");

  a_bar_last_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && !stage_i.last_line |=> !cursor_drawn_q)
    else $error("cursor bar off the last scanline");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o |=> out_valid_q)
    else $error("loaded word not presented");

endmodule

`default_nettype wire

>>> design/char_cell_screen_pixel_decoder.sv
// Top level: configuration registers and the two-stage decode pipeline.
//
//  channel   handshake               payload
//  in        in_valid_i/in_ready_o   screen_byte_i
//  out       out_valid_o/out_ready_i byte_address_o, pixel_x_o, pixel_y_o,
//                                    pixel_colours_o, cursor_drawn_o, frame_end_o
//  cfg       psel/penable/pwrite     paddr, pwdata, prdata (pready tied high)
//
// One word per cycle while out_ready_i is high; a word passes the input register, then
// the result register across the address and decode logic, before out_valid_o rises.
// Reset clears the scan counters and loads register defaults; no clearing pass.
// With out_ready_i low the result holds and one more word fits in the input register,
// after which in_ready_o drops.
`default_nettype none

module char_cell_screen_pixel_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  screen_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [14:0]      byte_address_o,
  output logic [10:0]      pixel_x_o,
  output logic [11:0]      pixel_y_o,
  output logic [31:0]      pixel_colours_o,
  output logic             cursor_drawn_o,
  output logic             frame_end_o
);

  typedef enum logic [2:0] {
    REG_START   = 3'd0,
    REG_CURSOR  = 3'd1,
    REG_CELLS   = 3'd2,
    REG_ROWS    = 3'd3,
    REG_LINES   = 3'd4,
    REG_MODE    = 3'd5,
    REG_WRAP    = 3'd6
  } reg_idx_e;

  logic [13:0] start_q, cursor_q;
  logic [7:0]  cells_q;
  logic [6:0]  rows_q;
  logic [5:0]  lines_q;
  logic [1:0]  mode_q, wrap_q;
  logic [2:0]  reg_idx;
  logic        wr_en;

  ccspd_pkg::cfg_t   cfg;
  ccspd_pkg::stage_t stage;
  logic              stage_valid;
  logic              advance;
  logic [5:0]        lines_eff;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= 14'd0;
      cursor_q <= 14'd0;
      cells_q  <= 8'd80;
      rows_q   <= 7'd32;
      lines_q  <= 6'd8;
      mode_q   <= ccspd_pkg::PM_ONE;
      wrap_q   <= 2'd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_START:  start_q  <= pwdata[13:0];
        REG_CURSOR: cursor_q <= pwdata[13:0];
        REG_CELLS:  cells_q  <= pwdata[7:0];
        REG_ROWS:   rows_q   <= pwdata[6:0];
        REG_LINES:  lines_q  <= pwdata[5:0];
        REG_MODE:   mode_q   <= pwdata[1:0];
        REG_WRAP:   wrap_q   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_START:  prdata = {18'd0, start_q};
      REG_CURSOR: prdata = {18'd0, cursor_q};
      REG_CELLS:  prdata = {24'd0, cells_q};
      REG_ROWS:   prdata = {25'd0, rows_q};
      REG_LINES:  prdata = {26'd0, lines_q};
      REG_MODE:   prdata = {30'd0, mode_q};
      REG_WRAP:   prdata = {30'd0, wrap_q};
      default:    prdata = '0;
    endcase
  end

  // zero geometry acts as one, more than 32 scanlines as 32
  always_comb begin
    if (lines_q == 6'd0) begin
      lines_eff = 6'd1;
    end else if (lines_q > 6'd32) begin
      lines_eff = 6'd32;
    end else begin
      lines_eff = lines_q;
    end
    cfg.start_address  = start_q;
    cfg.cursor_address = cursor_q;
    cfg.cells          = (cells_q == 8'd0) ? 8'd1 : cells_q;
    cfg.cells_m1       = (cells_q == 8'd0) ? 8'd0 : cells_q - 8'd1;
    cfg.rows_m1        = (rows_q == 7'd0) ? 7'd0 : rows_q - 7'd1;
    cfg.lines          = lines_eff;
    cfg.lines_m1       = 5'(lines_eff - 6'd1);
    cfg.pixel_mode     = mode_q;
    cfg.wrap_select    = wrap_q;
  end

  ccspd_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .screen_byte_i (screen_byte_i),
    .advance_i     (advance),
    .stage_valid_o (stage_valid),
    .stage_o       (stage)
  );

  ccspd_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .stage_valid_i   (stage_valid),
    .stage_i         (stage),
    .advance_o       (advance),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .byte_address_o  (byte_address_o),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_colours_o (pixel_colours_o),
    .cursor_drawn_o  (cursor_drawn_o),
    .frame_end_o     (frame_end_o)
  );

endmodule

`default_nettype wire
